// ----- rtl/srs_pkg.sv -----
// ----------------------------------------------------------------------------
// srs_pkg: shared types and constants for the stripe request splitter
// Strip and stripe widths, register map and the job record handed from the
// front end to the chunk generator.
// ----------------------------------------------------------------------------
`default_nettype none
package srs_pkg;

	localparam int OFF_W   = 32;
	localparam int LEN_W   = 32;
	localparam int FIRST_W = 4;
	localparam int WIDTH_W = 5;
	localparam int SRV_W   = 4;
	localparam int SOFF_W  = 48;
	localparam int CLEN_W  = 21;
	localparam int BOFF_W  = 32;

	localparam int KB_W    = 11;
	localparam int KB_MAX  = 1024;
	localparam int KB_RST  = 64;
	localparam int SHIFT_KB = 10;
	localparam int INNER_W = 20;
	localparam int SB_W    = KB_W + SHIFT_KB;

	localparam int DIV_NW  = 23;
	localparam int DIV_DW  = KB_W;

	localparam int PROD_W  = DIV_NW + KB_W;

	localparam int QUEUE_DEPTH = 2;

	localparam int MAX_CHUNKS_DEF  = 64;
	localparam int MAX_SERVERS_DEF = 16;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [PADDR_W-3:0] REG_STRIP_KB = '0;

	typedef struct packed {
		logic [WIDTH_W-1:0] srv;
		logic [SOFF_W-1:0]  base;
		logic [INNER_W-1:0] inner;
		logic [LEN_W-1:0]   len;
		logic [WIDTH_W-1:0] w;
		logic [SB_W-1:0]    sb;
	} job_t;

endpackage
`default_nettype wire

// ----- rtl/stripe_request_splitter.sv -----
// ----------------------------------------------------------------------------
// stripe_request_splitter: top level
// Splits a file request into per-strip chunks across a striped server set.
// ----------------------------------------------------------------------------
// A request holds the front end from its acceptance to the next one: the
// accepting step, two 23-step passes of the shared radix-2 divider (offset
// over strip size, then stripe slot over stripe width) each followed by a
// result step, a multiply step and a queue write, which waits while the
// queue is full. Requests that give no chunk leave after the first pass.
// Behind a two-entry job queue the chunk generator emits one chunk per clock
// while the output is not stalled, loading each job before its first chunk.
// The strip size register sits at byte address 0 and must be written while
// idle; the block does not enforce this.
`default_nettype none
module stripe_request_splitter #(
	parameter int MAX_CHUNKS  = srs_pkg::MAX_CHUNKS_DEF,
	parameter int MAX_SERVERS = srs_pkg::MAX_SERVERS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [srs_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [srs_pkg::PDATA_W-1:0]  pwdata,
	output logic [srs_pkg::PDATA_W-1:0]       prdata,
	output logic                              pready,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [srs_pkg::OFF_W-1:0]    byte_offset,
	input  wire logic [srs_pkg::LEN_W-1:0]    byte_length,
	input  wire logic [srs_pkg::FIRST_W-1:0]  first_server,
	input  wire logic [srs_pkg::WIDTH_W-1:0]  server_count,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [srs_pkg::SRV_W-1:0]         server_index,
	output logic [srs_pkg::SOFF_W-1:0]        server_byte_offset,
	output logic [srs_pkg::CLEN_W-1:0]        chunk_length,
	output logic [srs_pkg::BOFF_W-1:0]        buffer_offset,
	output logic                              last_chunk,
	output logic                              truncated
);
	logic [srs_pkg::KB_W-1:0] strip_kb_q;
	logic                     sel_strip;
	logic                     push;
	logic                     full;
	logic                     pop;
	logic                     empty;
	srs_pkg::job_t            wr_job;
	srs_pkg::job_t            rd_job;

	assign pready    = 1'b1;
	assign sel_strip = paddr[srs_pkg::PADDR_W-1:2] == srs_pkg::REG_STRIP_KB;
	assign prdata    = sel_strip ? srs_pkg::PDATA_W'(strip_kb_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strip_kb_q <= srs_pkg::KB_W'(srs_pkg::KB_RST);
		end else if (psel && penable && pwrite && pready && sel_strip) begin
			strip_kb_q <= pwdata[srs_pkg::KB_W-1:0];
		end
	end

	srs_front #(
		.MAX_SERVERS (MAX_SERVERS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.strip_kb     (strip_kb_q),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.byte_offset  (byte_offset),
		.byte_length  (byte_length),
		.first_server (first_server),
		.server_count (server_count),
		.push         (push),
		.job          (wr_job),
		.full         (full)
	);

	srs_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (wr_job),
		.full   (full),
		.pop    (pop),
		.rd_job (rd_job),
		.empty  (empty)
	);

	srs_back #(
		.MAX_CHUNKS (MAX_CHUNKS)
	) u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.job                (rd_job),
		.empty              (empty),
		.pop                (pop),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.server_index       (server_index),
		.server_byte_offset (server_byte_offset),
		.chunk_length       (chunk_length),
		.buffer_offset      (buffer_offset),
		.last_chunk         (last_chunk),
		.truncated          (truncated)
	);
endmodule
`default_nettype wire

// ----- rtl/srs_divider.sv -----
// ----------------------------------------------------------------------------
// srs_divider: shared restoring divider
// One quotient bit per clock; quotient and remainder hold after done.
// ----------------------------------------------------------------------------
`default_nettype none
module srs_divider (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [srs_pkg::DIV_NW-1:0] dividend,
	input  wire logic [srs_pkg::DIV_DW-1:0] divisor,
	output logic                            done,
	output logic [srs_pkg::DIV_NW-1:0]      quot,
	output logic [srs_pkg::DIV_DW-1:0]      rem
);
	localparam int NW = srs_pkg::DIV_NW;
	localparam int DW = srs_pkg::DIV_DW;
	localparam int CW = $clog2(NW);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] qd_q;
	logic [DW-1:0] r_q;
	logic [DW-1:0] d_q;
	logic [DW:0]   trial;
	logic          fits;

	assign trial = {r_q, qd_q[NW-1]};
	assign fits  = trial >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			qd_q <= dividend;
			r_q  <= '0;
			d_q  <= divisor;
		end else if (busy_q) begin
			qd_q <= {qd_q[NW-2:0], fits};
			r_q  <= fits ? DW'(trial - {1'b0, d_q}) : trial[DW-1:0];
		end
	end

	assign done = done_q;
	assign quot = qd_q;
	assign rem  = r_q;
endmodule
`default_nettype wire

// ----- rtl/srs_front.sv -----
// ----------------------------------------------------------------------------
// srs_front: request intake and classification
// Clamps strip and stripe sizes, finds the first strip, its stripe slot and
// server base offset, and drops requests that produce no chunk.
// ----------------------------------------------------------------------------
`default_nettype none
module srs_front #(
	parameter int MAX_SERVERS = srs_pkg::MAX_SERVERS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [srs_pkg::KB_W-1:0]    strip_kb,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [srs_pkg::OFF_W-1:0]   byte_offset,
	input  wire logic [srs_pkg::LEN_W-1:0]   byte_length,
	input  wire logic [srs_pkg::FIRST_W-1:0] first_server,
	input  wire logic [srs_pkg::WIDTH_W-1:0] server_count,
	output logic                             push,
	output srs_pkg::job_t                    job,
	input  wire logic                        full
);
	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV_STRIP,
		S_DIV_STRIPE,
		S_MUL,
		S_PUSH
	} state_t;

	state_t state_q;

	logic [srs_pkg::OFF_W-1:0]   off_q;
	logic [srs_pkg::LEN_W-1:0]   len_q;
	logic [srs_pkg::FIRST_W-1:0] first_q;
	logic [srs_pkg::WIDTH_W-1:0] w_q;
	logic [srs_pkg::KB_W-1:0]    kb_q;
	logic [srs_pkg::INNER_W-1:0] inner_q;
	logic [srs_pkg::WIDTH_W-1:0] srv_q;
	logic [srs_pkg::DIV_NW-1:0]  q0_q;
	logic [srs_pkg::PROD_W-1:0]  prod_q;

	logic [srs_pkg::KB_W-1:0]    kb_eff;
	logic [srs_pkg::WIDTH_W-1:0] w_eff;
	logic                        accept;
	logic                        empty_req;
	logic                        div_start;
	logic                        div_done;
	logic [srs_pkg::DIV_NW-1:0]  div_dividend;
	logic [srs_pkg::DIV_DW-1:0]  div_divisor;
	logic [srs_pkg::DIV_NW-1:0]  div_quot;
	logic [srs_pkg::DIV_DW-1:0]  div_rem;

	always_comb begin
		priority if (strip_kb == '0)
			kb_eff = srs_pkg::KB_W'(1);
		else if (32'(strip_kb) > srs_pkg::KB_MAX)
			kb_eff = srs_pkg::KB_W'(srs_pkg::KB_MAX);
		else
			kb_eff = strip_kb;
	end

	always_comb begin
		priority if (server_count == '0)
			w_eff = srs_pkg::WIDTH_W'(1);
		else if (32'(server_count) > MAX_SERVERS)
			w_eff = srs_pkg::WIDTH_W'(MAX_SERVERS);
		else
			w_eff = server_count;
	end

	assign in_ready  = state_q == S_IDLE;
	assign accept    = in_ready && in_valid;
	assign empty_req = (len_q == '0) && (div_rem[srs_pkg::SHIFT_KB-1:0] == '0)
		&& (off_q[srs_pkg::SHIFT_KB-1:0] == '0);

	assign div_start = accept || (state_q == S_DIV_STRIP && div_done && !empty_req);
	assign div_dividend = (state_q == S_IDLE)
		? srs_pkg::DIV_NW'(byte_offset[srs_pkg::OFF_W-1:srs_pkg::SHIFT_KB])
		: srs_pkg::DIV_NW'(first_q) + div_quot;
	assign div_divisor = (state_q == S_IDLE) ? kb_eff : srs_pkg::DIV_DW'(w_q);

	srs_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_DIV_STRIP;
					end
				end
				S_DIV_STRIP: begin
					if (div_done) begin
						state_q <= empty_req ? S_IDLE : S_DIV_STRIPE;
					end
				end
				S_DIV_STRIPE: begin
					if (div_done) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_PUSH;
				end
				S_PUSH: begin
					if (!full) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			off_q   <= byte_offset;
			len_q   <= byte_length;
			first_q <= first_server;
			w_q     <= w_eff;
			kb_q    <= kb_eff;
		end
		if (state_q == S_DIV_STRIP && div_done) begin
			inner_q <= {div_rem[srs_pkg::SHIFT_KB-1:0], off_q[srs_pkg::SHIFT_KB-1:0]};
		end
		if (state_q == S_DIV_STRIPE && div_done) begin
			srv_q <= div_rem[srs_pkg::WIDTH_W-1:0];
			q0_q  <= div_quot;
		end
		if (state_q == S_MUL) begin
			prod_q <= srs_pkg::PROD_W'(q0_q) * srs_pkg::PROD_W'(kb_q);
		end
	end

	assign push      = (state_q == S_PUSH) && !full;
	assign job.srv   = srv_q;
	assign job.base  = srs_pkg::SOFF_W'({prod_q, {srs_pkg::SHIFT_KB{1'b0}}});
	assign job.inner = inner_q;
	assign job.len   = len_q;
	assign job.w     = w_q;
	assign job.sb    = {kb_q, {srs_pkg::SHIFT_KB{1'b0}}};
endmodule
`default_nettype wire

// ----- rtl/srs_queue.sv -----
// ----------------------------------------------------------------------------
// srs_queue: job queue
// Short first-in first-out store between the front end and the chunk
// generator.
// ----------------------------------------------------------------------------
`default_nettype none
module srs_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire srs_pkg::job_t wr_job,
	output logic               full,
	input  wire logic          pop,
	output srs_pkg::job_t      rd_job,
	output logic               empty
);
	localparam int DEPTH = srs_pkg::QUEUE_DEPTH;
	localparam int PW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	srs_pkg::job_t entry_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full   = count_q == CW'(DEPTH);
	assign empty  = count_q == '0;
	assign rd_job = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_job;
		end
	end
endmodule
`default_nettype wire

// ----- rtl/srs_back.sv -----
// ----------------------------------------------------------------------------
// srs_back: chunk generator
// Walks the strips of one job into an output register, one chunk per clock unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none
module srs_back #(
	parameter int MAX_CHUNKS = srs_pkg::MAX_CHUNKS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire srs_pkg::job_t                job,
	input  wire logic                         empty,
	output logic                              pop,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [srs_pkg::SRV_W-1:0]         server_index,
	output logic [srs_pkg::SOFF_W-1:0]        server_byte_offset,
	output logic [srs_pkg::CLEN_W-1:0]        chunk_length,
	output logic [srs_pkg::BOFF_W-1:0]        buffer_offset,
	output logic                              last_chunk,
	output logic                              truncated
);
	localparam int CW = $clog2(MAX_CHUNKS + 1);

	logic                         active_q;
	logic [srs_pkg::WIDTH_W-1:0]  srv_q;
	logic [srs_pkg::SOFF_W-1:0]   base_q;
	logic [srs_pkg::INNER_W-1:0]  inner_q;
	logic [srs_pkg::LEN_W-1:0]    rem_q;
	logic [srs_pkg::BOFF_W-1:0]   boff_q;
	logic [srs_pkg::WIDTH_W-1:0]  w_q;
	logic [srs_pkg::SB_W-1:0]     sb_q;
	logic [CW-1:0]                cnt_q;
	logic                         out_valid_q;

	logic [srs_pkg::SB_W-1:0]     avail;
	logic                         fits_all;
	logic                         at_limit;
	logic [srs_pkg::CLEN_W-1:0]   clen;
	logic                         advance;
	logic                         is_last;
	logic [srs_pkg::WIDTH_W:0]    srv_inc;

	assign avail    = sb_q - srs_pkg::SB_W'(inner_q);
	assign fits_all = rem_q <= srs_pkg::LEN_W'(avail);
	assign clen     = fits_all ? srs_pkg::CLEN_W'(rem_q) : srs_pkg::CLEN_W'(avail);
	assign at_limit = cnt_q == CW'(MAX_CHUNKS - 1);
	assign is_last  = fits_all || at_limit;
	assign advance  = active_q && (!out_valid_q || out_ready);
	assign pop      = !active_q && !empty;
	assign srv_inc  = {1'b0, srv_q} + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				active_q <= 1'b1;
			end else if (advance && is_last) begin
				active_q <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			srv_q   <= job.srv;
			base_q  <= job.base;
			inner_q <= job.inner;
			rem_q   <= job.len;
			boff_q  <= '0;
			w_q     <= job.w;
			sb_q    <= job.sb;
			cnt_q   <= '0;
		end else if (advance) begin
			inner_q <= '0;
			rem_q   <= rem_q - srs_pkg::LEN_W'(clen);
			boff_q  <= boff_q + srs_pkg::BOFF_W'(clen);
			cnt_q   <= cnt_q + 1'b1;
			if (srv_inc == {1'b0, w_q}) begin
				srv_q  <= '0;
				base_q <= base_q + srs_pkg::SOFF_W'(sb_q);
			end else begin
				srv_q <= srv_inc[srs_pkg::WIDTH_W-1:0];
			end
		end
		if (advance) begin
			server_index       <= srv_q[srs_pkg::SRV_W-1:0];
			server_byte_offset <= base_q + srs_pkg::SOFF_W'(inner_q);
			chunk_length       <= clen;
			buffer_offset      <= boff_q;
			last_chunk         <= is_last;
			truncated          <= !fits_all && at_limit;
		end
	end

	assign out_valid = out_valid_q;
endmodule
`default_nettype wire

// ----- rtl/srs_checker.sv -----
// ----------------------------------------------------------------------------
// srs_checker: port-level checks for the stripe request splitter
// Watches the result channel and flags malformed chunk sequences.
// ----------------------------------------------------------------------------
`default_nettype none
module srs_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic [srs_pkg::CLEN_W-1:0]  chunk_length,
	input wire logic                        last_chunk,
	input wire logic                        truncated
);
	localparam logic [srs_pkg::CLEN_W-1:0] STRIP_MAX =
		srs_pkg::CLEN_W'(srs_pkg::KB_MAX * 1024);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(chunk_length)
			&& $stable(last_chunk) && $stable(truncated))
		else $error("item dropped or changed while stalled");

	a_trunc_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && truncated |-> last_chunk)
		else $error("truncated item is not the last of its request");

	a_len_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> chunk_length <= STRIP_MAX)
		else $error("chunk longer than the largest strip");

	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_chunk |-> chunk_length != '0)
		else $error("empty chunk in the middle of a request");
endmodule

bind stripe_request_splitter srs_checker u_srs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.chunk_length (chunk_length),
	.last_chunk   (last_chunk),
	.truncated    (truncated)
);
`default_nettype wire
